// File: hw/rtl/max_prefix_sum_segment_tree_assert.svh
// Assertion macros for the max prefix sum segment tree.
// Used by the top level; expects clk and rst in scope.
`ifndef MAX_PREFIX_SUM_SEGMENT_TREE_ASSERT_SVH
`define MAX_PREFIX_SUM_SEGMENT_TREE_ASSERT_SVH

// cond must hold on every edge outside reset
`define MPST_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define MPST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define MPST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mpst_pkg.sv
// Shared constants and controller/datapath interface types for the
// max prefix sum segment tree. No dependencies.
package mpst_pkg;

  localparam int LEAVES_DEFAULT = 1024;
  localparam int SIZE_W         = 11;
  localparam int IDX_W          = 10;
  localparam int VAL_W          = 32;
  localparam int OUT_W          = 41;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // item opcodes
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic clr;       // zero one node of the clearing pass
    logic load;      // capture an input item
    logic set_leaf;  // write the leaf of a set item
    logic rd_kl;     // read left child of k
    logic rd_kr;     // read right child of k
    logic wr_node;   // write combined children into k, move up
    logic q_init;    // start a query walk
    logic q_zero;    // empty query range
    logic rd_ql;     // read node l
    logic rd_qr;     // read node r-1
    logic q_acc;     // fold nodes into the accumulators, move up
    logic q_fin;     // join left and right accumulators
    logic q_out;     // load the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic set_ok;
    logic q_nonempty;
    logic k_root;
    logic l_lt_r;
    logic out_busy;
  } stat_t;

endpackage

// File: hw/rtl/mpst_ctrl.sv
// Controller state machine for the max prefix sum segment tree.
// Depends on mpst_pkg; drives mpst_dp through cmd_t, watches stat_t.
module mpst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mpst_pkg::stat_t st,
  output mpst_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    CLEAR, IDLE, DECIDE, S_LEAF, S_RDL, S_RDR, S_WR,
    Q_CHK, Q_RDL, Q_RDR, Q_ACC, Q_FIN, OUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_next = IDLE;
      end
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = DECIDE;
        end
      end
      DECIDE: begin
        if (st.is_query) begin
          if (st.q_nonempty) begin
            cmd.q_init = 1'b1;
            state_next = Q_CHK;
          end else begin
            cmd.q_zero = 1'b1;
            state_next = OUT;
          end
        end else if (st.set_ok) begin
          state_next = S_LEAF;
        end else begin
          state_next = IDLE;
        end
      end
      S_LEAF: begin
        cmd.set_leaf = 1'b1;
        state_next   = S_RDL;
      end
      S_RDL: begin
        cmd.rd_kl  = 1'b1;
        state_next = S_RDR;
      end
      S_RDR: begin
        cmd.rd_kr  = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_node = 1'b1;
        state_next  = st.k_root ? IDLE : S_RDL;
      end
      Q_CHK: begin
        state_next = st.l_lt_r ? Q_RDL : Q_FIN;
      end
      Q_RDL: begin
        cmd.rd_ql  = 1'b1;
        state_next = Q_RDR;
      end
      Q_RDR: begin
        cmd.rd_qr  = 1'b1;
        state_next = Q_ACC;
      end
      Q_ACC: begin
        cmd.q_acc  = 1'b1;
        state_next = Q_CHK;
      end
      Q_FIN: begin
        cmd.q_fin  = 1'b1;
        state_next = OUT;
      end
      OUT: begin
        // hold until the output register is free
        if (!st.out_busy) begin
          cmd.q_out  = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mpst_dp.sv
// Datapath for the max prefix sum segment tree: node memory, item
// registers, tree walk pointers, accumulators and output register. Uses mpst_pkg.
module mpst_dp #(
  parameter int LEAVES = mpst_pkg::LEAVES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mpst_pkg::cmd_t                    cmd,
  output mpst_pkg::stat_t                   st,
  input  logic                              cfg_we,
  input  logic [mpst_pkg::SIZE_W-1:0]       cfg_data,
  input  logic                              op,
  input  logic [mpst_pkg::IDX_W-1:0]        index,
  input  logic signed [mpst_pkg::VAL_W-1:0] value,
  input  logic [mpst_pkg::IDX_W-1:0]        range_low,
  input  logic [mpst_pkg::IDX_W-1:0]        range_high,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mpst_pkg::OUT_W-1:0]        best_prefix
);

  localparam int AW     = $clog2(LEAVES) + 1;
  localparam int SUM_W  = mpst_pkg::VAL_W + $clog2(LEAVES);
  localparam int NODE_W = 2 * SUM_W;
  localparam int W      = (AW + 1 > 12) ? AW + 1 : 12;
  localparam int CW     = ((SUM_W > mpst_pkg::OUT_W + 1) ? SUM_W : mpst_pkg::OUT_W + 1) + 1;
  localparam int DEPTH  = 2 * LEAVES;

  function automatic logic [NODE_W-1:0] join_node(input logic [NODE_W-1:0] a,
                                                  input logic [NODE_W-1:0] b);
    logic signed [SUM_W-1:0] a_s, a_p, b_s, b_p, alt, s, p;
    a_s = a[NODE_W-1:SUM_W];
    a_p = a[SUM_W-1:0];
    b_s = b[NODE_W-1:SUM_W];
    b_p = b[SUM_W-1:0];
    alt = a_s + b_p;
    s   = a_s + b_s;
    p   = (a_p > alt) ? a_p : alt;
    return {s, p};
  endfunction

  logic [NODE_W-1:0] mem [DEPTH];
  logic [NODE_W-1:0] rdata;
  logic [AW-1:0]     raddr, waddr;
  logic [NODE_W-1:0] wdata;
  logic              we;

  logic [mpst_pkg::SIZE_W-1:0]       size_in_use;
  logic                              op_q;
  logic [mpst_pkg::IDX_W-1:0]        idx_q, lo_q, hi_q;
  logic signed [mpst_pkg::VAL_W-1:0] val_q;
  logic [AW-1:0]                     clr_addr;
  logic [AW-1:0]                     k;
  logic [W-1:0]                      l, r;
  logic [NODE_W-1:0]                 lreg, left_n, right_n;
  logic                              left_empty, right_empty;
  logic signed [SUM_W-1:0]           all_pre;

  logic [W-1:0]      n, n1, size_w, hi_c, leaf_addr;
  logic [NODE_W-1:0] left_new, right_new, all_n;
  logic [SUM_W-1:0]  val_ext;
  logic signed [CW-1:0] all_ext;
  logic [mpst_pkg::OUT_W-1:0] clamp;

  // effective size and range checks
  always_comb begin
    size_w    = W'(size_in_use);
    n         = (size_w < W'(LEAVES)) ? size_w : W'(LEAVES);
    n1        = n - W'(1);
    hi_c      = (W'(hi_q) > n1) ? n1 : W'(hi_q);
    leaf_addr = W'(LEAVES) + W'(idx_q);
    val_ext   = {{(SUM_W - mpst_pkg::VAL_W){val_q[mpst_pkg::VAL_W-1]}}, val_q};
  end

  always_comb begin
    st.clr_last   = (clr_addr == '1);
    st.is_query   = (op_q == mpst_pkg::OP_QUERY);
    st.set_ok     = (W'(idx_q) < n);
    st.q_nonempty = (n != '0) && (W'(lo_q) <= hi_c);
    st.k_root     = (k == AW'(1));
    st.l_lt_r     = (l < r);
    st.out_busy   = out_valid && !out_ready;
  end

  // memory ports
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (cmd.clr) begin
      we = 1'b1;
    end else if (cmd.set_leaf) begin
      we    = 1'b1;
      waddr = leaf_addr[AW-1:0];
      wdata = {val_ext, val_ext};
    end else if (cmd.wr_node) begin
      we    = 1'b1;
      waddr = k;
      wdata = join_node(lreg, rdata);
    end
    if (cmd.rd_kl) begin
      raddr = {k[AW-2:0], 1'b0};
    end else if (cmd.rd_kr) begin
      raddr = {k[AW-2:0], 1'b1};
    end else if (cmd.rd_ql) begin
      raddr = l[AW-1:0];
    end else begin
      raddr = AW'(r - W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // query accumulators
  always_comb begin
    left_new  = left_empty  ? lreg  : join_node(left_n, lreg);
    right_new = right_empty ? rdata : join_node(rdata, right_n);
    if (left_empty) begin
      all_n = right_n;
    end else if (right_empty) begin
      all_n = left_n;
    end else begin
      all_n = join_node(left_n, right_n);
    end
    all_ext = {{(CW - SUM_W){all_pre[SUM_W-1]}}, all_pre};
    if (all_ext <= 0) begin
      clamp = '0;
    end else if (all_ext > $signed({{(CW - mpst_pkg::OUT_W){1'b0}}, mpst_pkg::OUT_MAX})) begin
      clamp = mpst_pkg::OUT_MAX;
    end else begin
      clamp = all_ext[mpst_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= mpst_pkg::SIZE_W'(1024);
      clr_addr    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) size_in_use <= cfg_data;
      if (cmd.clr) clr_addr <= clr_addr + AW'(1);
      if (cmd.q_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      idx_q <= index;
      val_q <= value;
      lo_q  <= range_low;
      hi_q  <= range_high;
    end
    if (cmd.set_leaf) k <= leaf_addr[AW:1];
    if (cmd.wr_node) k <= k >> 1;
    if (cmd.rd_kr || cmd.rd_qr) lreg <= rdata;
    if (cmd.q_init) begin
      l           <= W'(LEAVES) + W'(lo_q);
      r           <= W'(LEAVES) + hi_c + W'(1);
      left_empty  <= 1'b1;
      right_empty <= 1'b1;
    end
    if (cmd.q_acc) begin
      if (l[0]) begin
        left_n     <= left_new;
        left_empty <= 1'b0;
      end
      if (r[0]) begin
        right_n     <= right_new;
        right_empty <= 1'b0;
      end
      l <= (l + W'(l[0])) >> 1;
      r <= (r - W'(r[0])) >> 1;
    end
    if (cmd.q_fin) all_pre <= all_n[SUM_W-1:0];
    if (cmd.q_zero) all_pre <= '0;
    if (cmd.q_out) best_prefix <= clamp;
  end

endmodule

// File: hw/rtl/max_prefix_sum_segment_tree.sv
// Max prefix sum segment tree, top level: mpst_ctrl plus mpst_dp. Uses mpst_pkg.
// One item at a time through a node memory with one write port and one registered read port.
// Set: write the leaf, then per level read two children and write the parent.
// Query: per tree level walked, read nodes l and r-1 and fold them into the accumulators.
// Reset: synchronous; a clearing pass zeroes all 2*LEAVES nodes
// before the first item is taken, configuration writes are taken meanwhile.
`include "max_prefix_sum_segment_tree_assert.svh"
module max_prefix_sum_segment_tree #(
  parameter int LEAVES = mpst_pkg::LEAVES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpst_pkg::SIZE_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [mpst_pkg::IDX_W-1:0]        index,
  input  logic signed [mpst_pkg::VAL_W-1:0] value,
  input  logic [mpst_pkg::IDX_W-1:0]        range_low,
  input  logic [mpst_pkg::IDX_W-1:0]        range_high,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mpst_pkg::OUT_W-1:0]        best_prefix
);

  mpst_pkg::cmd_t  cmd;
  mpst_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  mpst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mpst_dp #(.LEAVES(LEAVES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .op          (op),
    .index       (index),
    .value       (value),
    .range_low   (range_low),
    .range_high  (range_high),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .best_prefix (best_prefix)
  );

  `MPST_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")
  `MPST_ASSERT_ALWAYS(a_one_write, $onehot0({cmd.clr, cmd.set_leaf, cmd.wr_node}), "write clash")
  `MPST_ASSERT_IMP(a_set_in_range, cmd.set_leaf, st.set_ok, "set beyond size")
  `MPST_ASSERT_IMP(a_out_free, cmd.q_out, !st.out_busy, "result overwrites pending transfer")

endmodule

// File: bench/tb_max_prefix_sum_segment_tree.sv
// Self-checking bench for max_prefix_sum_segment_tree: random set/query traffic
// with a behavioral segment tree predicting every query answer.
// Depends on mpst_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_max_prefix_sum_segment_tree;

  localparam int NLEAF = mpst_pkg::LEAVES_DEFAULT;
  localparam int IDX_W = mpst_pkg::IDX_W;
  localparam int VAL_W = mpst_pkg::VAL_W;
  localparam int SIZE_W = mpst_pkg::SIZE_W;
  localparam int OUT_W = mpst_pkg::OUT_W;
  localparam logic [OUT_W-1:0] OUT_MAX = mpst_pkg::OUT_MAX;
  localparam longint IDENT_PRE = -64'sh4000000000000000;
  localparam int SETTLE = 100;
  localparam longint LIMIT = 3000000;
  localparam bit OP_SET = mpst_pkg::OP_SET;
  localparam bit OP_QUERY = mpst_pkg::OP_QUERY;

  typedef struct {
    bit op;
    logic [IDX_W-1:0] idx;
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } tree_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_SET;
  logic [IDX_W-1:0] index = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic [IDX_W-1:0] range_low = '0;
  logic [IDX_W-1:0] range_high = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_W-1:0] best_prefix;

  max_prefix_sum_segment_tree dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .index(index), .value(value),
    .range_low(range_low), .range_high(range_high),
    .out_valid(out_valid), .out_ready(out_ready), .best_prefix(best_prefix)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  longint span_sum [0:2*NLEAF-1];
  longint span_pre [0:2*NLEAF-1];
  int unsigned size_reg = 1024;

  tree_op_t pending_ops[$];
  logic [OUT_W-1:0] expected_best[$];
  tree_op_t cur;
  bit in_fire = 0;
  bit quiet = 0;
  int in_gap = 0;
  int out_gap = 0;
  int n_sets = 0, n_queries = 0, n_checked = 0, n_errs = 0;
  longint cycles = 0;

  function automatic int unsigned eff_size();
    return (size_reg < NLEAF) ? size_reg : NLEAF;
  endfunction

  function automatic void join_spans(input longint as, input longint ap,
                                     input longint bs, input longint bp,
                                     output longint rs, output longint rp);
    longint alt;
    alt = as + bp;
    rs = as + bs;
    rp = (ap > alt) ? ap : alt;
  endfunction

  function automatic void write_element(input int unsigned i, input longint v);
    int unsigned k;
    if (i >= eff_size()) return;
    k = NLEAF + i;
    span_sum[k] = v;
    span_pre[k] = v;
    k = k >> 1;
    while (k >= 1) begin
      join_spans(span_sum[2*k], span_pre[2*k], span_sum[2*k+1], span_pre[2*k+1],
                 span_sum[k], span_pre[k]);
      k = k >> 1;
    end
  endfunction

  function automatic logic [OUT_W-1:0] range_best_prefix(input int unsigned lo,
                                                         input int unsigned hi);
    int unsigned n, l, r;
    longint ls, lp, rs, rp, as, ap;
    n = eff_size();
    ls = 0; lp = IDENT_PRE; rs = 0; rp = IDENT_PRE;
    if (n == 0) return '0;
    if (hi > n - 1) hi = n - 1;
    if (lo > hi) return '0;
    l = lo + NLEAF;
    r = hi + NLEAF + 1;
    while (l < r) begin
      if (l & 1) begin
        join_spans(ls, lp, span_sum[l], span_pre[l], ls, lp);
        l++;
      end
      if (r & 1) begin
        r--;
        join_spans(span_sum[r], span_pre[r], rs, rp, rs, rp);
      end
      l = l >> 1;
      r = r >> 1;
    end
    join_spans(ls, lp, rs, rp, as, ap);
    if (ap <= 0) return '0;
    if (ap > longint'(OUT_MAX)) return OUT_MAX;
    return ap[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    n_errs++;
    $display("MISMATCH @%0d: %s", cycles, what);
  endtask

  // sample side: transfers are seen at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("max_prefix_sum_segment_tree regression: fail");
      $finish;
    end
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_fire = 1;
        if (cur.op == OP_SET) begin
          n_sets++;
          write_element(cur.idx, longint'(cur.val));
        end else begin
          n_queries++;
          expected_best.push_back(range_best_prefix(cur.lo, cur.hi));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_best.size() == 0)
          report_mismatch($sformatf("unexpected result %0d", best_prefix));
        else begin
          logic [OUT_W-1:0] want;
          want = expected_best.pop_front();
          n_checked++;
          if (best_prefix !== want)
            report_mismatch($sformatf("best_prefix %0d, want %0d", best_prefix, want));
        end
      end
    end
  end

  // drive side: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      in_fire = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur = pending_ops.pop_front();
        in_valid <= 1'b1;
        op <= cur.op;
        index <= cur.idx;
        value <= cur.val;
        range_low <= cur.lo;
        range_high <= cur.hi;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 13);
    end
  end

  task automatic push_set(input int unsigned i, input logic signed [VAL_W-1:0] v);
    tree_op_t t;
    t.op = OP_SET; t.idx = IDX_W'(i); t.val = v;
    t.lo = IDX_W'($urandom); t.hi = IDX_W'($urandom);
    pending_ops.push_back(t);
  endtask

  task automatic push_query(input int unsigned lo, input int unsigned hi);
    tree_op_t t;
    t.op = OP_QUERY; t.lo = IDX_W'(lo); t.hi = IDX_W'(hi);
    t.idx = IDX_W'($urandom); t.val = $urandom;
    pending_ops.push_back(t);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 400)) - 200;
    endcase
  endfunction

  task automatic queue_random(input int count);
    int unsigned n, lo;
    n = eff_size();
    repeat (count) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if (n > 0 && r < 44) push_set($urandom_range(0, n - 1), pick_value());
        else push_set($urandom_range(0, NLEAF - 1), pick_value());
      end else if (n > 0 && r < 92) begin
        lo = $urandom_range(0, n - 1);
        push_query(lo, $urandom_range(lo, n - 1));
      end else begin
        push_query($urandom_range(0, NLEAF - 1), $urandom_range(0, NLEAF - 1));
      end
    end
  endtask

  // wait until the block has drained, then let any trailing set finish
  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_best.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input int unsigned s);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= SIZE_W'(s);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_reg = s;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sizes[6] = '{37, 2047, 0, 1, 600, 1024};
    for (int k = 0; k < 2 * NLEAF; k++) begin
      span_sum[k] = 0;
      span_pre[k] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, empty and inverted ranges, all-negative span
    push_query(0, 1023);
    push_set(0, 32'sh7fffffff);
    push_set(1023, 32'sh80000000);
    push_set(1, 32'sh7fffffff);
    push_set(2, -5);
    push_set(900, 1234);
    push_query(0, 0);
    push_query(1023, 1023);
    push_query(0, 1023);
    push_query(2, 2);
    push_query(5, 3);
    push_query(1, 2);
    push_query(899, 1023);
    for (int i = 10; i < 14; i++) push_set(i, 32'sh80000000);
    push_query(10, 13);
    push_query(9, 14);
    push_set(40, 32'shffffffff);
    push_query(40, 40);
    drain();

    foreach (sizes[p]) begin
      write_size(sizes[p]);
      // shrunk or raised size: old elements must hide or reappear
      push_query(0, 1023);
      push_set(1000, 77);
      push_query(sizes[p] == 0 ? 0 : sizes[p] - 1, 1023);
      if (p == 5) quiet = 1;
      queue_random(p == 1 || p == 5 ? 400 : 150);
      drain();
    end

    $display("%0d sets and %0d queries sent, %0d results checked, sizes 0..2047",
             n_sets, n_queries, n_checked);
    if (n_errs == 0 && expected_best.size() == 0)
      $display("max_prefix_sum_segment_tree regression: pass");
    else
      $display("max_prefix_sum_segment_tree regression: fail");
    $finish;
  end

endmodule

// File: max_prefix_sum_segment_tree.f
+incdir+hw/rtl
hw/rtl/mpst_pkg.sv
hw/rtl/mpst_ctrl.sv
hw/rtl/mpst_dp.sv
hw/rtl/max_prefix_sum_segment_tree.sv
bench/tb_max_prefix_sum_segment_tree.sv
